FILE: src/cfs_pkg.sv
// Shared types and constants for the command flag sequencer.
// Transfer structs, action codes, command characters and flag bit positions.
// No dependencies.
package cfs_pkg;

  // Digit entry limit default
  localparam int MAX_DIGITS_DEF = 4;

  // Item actions
  typedef enum logic [2:0] {
    ACT_COMMAND = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_SERVICE = 3'd2,
    ACT_SET     = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  // Command characters
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_F = 8'h66;

  // ASCII '0', subtracted from each digit byte
  localparam logic [15:0] DIGIT_BASE = 16'd48;

  // Flag bit positions
  localparam int FLAG_SAMPLE = 0;
  localparam int FLAG_ENTRY  = 1;
  localparam int FLAG_ZERO   = 2;
  localparam int FLAG_RS232  = 3;
  localparam int FLAG_V12    = 4;
  localparam int FLAG_RUN    = 7;

  localparam int DCOUNT_W = 3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [7:0] flag_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic        sample_now;
    logic        depth_zero_now;
    logic        rs232_on;
    logic        power12_on;
    logic        ran;
    logic [15:0] interval_seconds;
  } out_item_t;

endpackage

FILE: src/cfs_in_reg.sv
// Input register stage of the command flag sequencer.
// Holds one accepted item until the core takes it; uses cfs_pkg.
module cfs_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfs_pkg::in_item_t in_data,
  input  logic              take,
  output logic              stage_valid,
  output cfs_pkg::in_item_t stage_data
);
  import cfs_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t data_r;
  logic     accept;

  // Stall only while a held item cannot move on
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  // Advance the valid bit
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign stage_valid = valid_r;
  assign stage_data  = data_r;

  property p_take_needs_item;
    @(posedge clk) disable iff (!rst_n) take |-> valid_r;
  endproperty
  a_take_needs_item: assert property (p_take_needs_item)
    else $error("core took an item from an empty input stage");

  property p_accept_fills;
    @(posedge clk) disable iff (!rst_n) accept |=> valid_r;
  endproperty
  a_accept_fills: assert property (p_accept_fills)
    else $error("accepted item lost in input stage");

  property p_drain_empties;
    @(posedge clk) disable iff (!rst_n) (take && !accept) |=> !valid_r;
  endproperty
  a_drain_empties: assert property (p_drain_empties)
    else $error("input stage kept an item after it was taken");

endmodule

FILE: src/cfs_core.sv
// State and step logic of the command flag sequencer.
// Flags, interval entry, tick counter and output levels; uses cfs_pkg.
module cfs_core #(
  parameter int MAX_DIGITS = cfs_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  cfs_pkg::in_item_t  item,
  output cfs_pkg::out_item_t result
);
  import cfs_pkg::*;

  logic [7:0]          flag_bits_r, flag_bits_nxt;
  logic [15:0]         interval_r, interval_nxt;
  logic [15:0]         tick_count_r, tick_count_nxt;
  logic [DCOUNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [15:0]         digit_value_r, digit_value_nxt;
  logic                rs232_r, rs232_nxt;
  logic                power_r, power_nxt;
  logic                sample_now, zero_now, ran;
  logic [15:0]         tick_inc;
  logic [15:0]         digit_acc;
  logic [7:0]          c;

  assign c         = item.data_byte;
  assign tick_inc  = tick_count_r + 16'd1;
  // value*10 + byte - '0', wrapping at 16 bits
  assign digit_acc = (digit_value_r << 3) + (digit_value_r << 1)
                     + {8'd0, c} - DIGIT_BASE;

  // Next state for one item
  always_comb begin
    flag_bits_nxt   = flag_bits_r;
    interval_nxt    = interval_r;
    tick_count_nxt  = tick_count_r;
    digit_count_nxt = digit_count_r;
    digit_value_nxt = digit_value_r;
    rs232_nxt       = rs232_r;
    power_nxt       = power_r;
    sample_now      = 1'b0;
    zero_now        = 1'b0;
    ran             = 1'b0;
    case (item.action)
      ACT_COMMAND: begin
        if (c == CH_A) begin
          flag_bits_nxt[FLAG_SAMPLE] = ~flag_bits_r[FLAG_SAMPLE];
        end else if (c == CH_B) begin
          // Open or close interval entry
          if (flag_bits_r[FLAG_ENTRY]) begin
            flag_bits_nxt[FLAG_ENTRY] = 1'b0;
            interval_nxt = digit_value_r;
          end else begin
            flag_bits_nxt[FLAG_ENTRY] = 1'b1;
          end
          digit_count_nxt = '0;
          digit_value_nxt = '0;
        end else if (flag_bits_r[FLAG_ENTRY]) begin
          // Take a digit unless the entry is full
          if (digit_count_r < DCOUNT_W'(MAX_DIGITS)) begin
            digit_value_nxt = digit_acc;
            digit_count_nxt = digit_count_r + DCOUNT_W'(1);
          end
        end else if (c == CH_C) begin
          flag_bits_nxt[FLAG_ZERO] = ~flag_bits_r[FLAG_ZERO];
        end else if (c == CH_D) begin
          flag_bits_nxt[FLAG_RS232] = ~flag_bits_r[FLAG_RS232];
        end else if (c == CH_E) begin
          flag_bits_nxt[FLAG_V12] = ~flag_bits_r[FLAG_V12];
        end else if (c == CH_F) begin
          flag_bits_nxt  = '0;
          interval_nxt   = 16'd1;
          tick_count_nxt = '0;
        end
      end
      ACT_TICK: begin
        // Count and raise run once per interval
        tick_count_nxt = tick_inc;
        if (tick_inc >= interval_r) begin
          flag_bits_nxt[FLAG_RUN] = 1'b1;
          tick_count_nxt = '0;
        end
      end
      ACT_SERVICE: begin
        if (flag_bits_r[FLAG_RUN]) begin
          ran        = 1'b1;
          sample_now = flag_bits_r[FLAG_SAMPLE];
          zero_now   = flag_bits_r[FLAG_ZERO];
          rs232_nxt  = flag_bits_r[FLAG_RS232];
          power_nxt  = flag_bits_r[FLAG_V12];
          flag_bits_nxt[FLAG_RUN]  = 1'b0;
          flag_bits_nxt[FLAG_ZERO] = 1'b0;
        end
      end
      ACT_SET: begin
        flag_bits_nxt = flag_bits_r | item.flag_mask;
      end
      ACT_CLEAR: begin
        flag_bits_nxt = flag_bits_r & ~item.flag_mask;
      end
      default: begin
      end
    endcase
  end

  // Hold state between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_bits_r   <= '0;
      interval_r    <= 16'd1;
      tick_count_r  <= '0;
      digit_count_r <= '0;
      digit_value_r <= '0;
      rs232_r       <= 1'b0;
      power_r       <= 1'b0;
    end else if (step) begin
      flag_bits_r   <= flag_bits_nxt;
      interval_r    <= interval_nxt;
      tick_count_r  <= tick_count_nxt;
      digit_count_r <= digit_count_nxt;
      digit_value_r <= digit_value_nxt;
      rs232_r       <= rs232_nxt;
      power_r       <= power_nxt;
    end
  end

  // Result reflects state after the step
  always_comb begin
    result.flags            = flag_bits_nxt;
    result.sample_now       = sample_now;
    result.depth_zero_now   = zero_now;
    result.rs232_on         = rs232_nxt;
    result.power12_on       = power_nxt;
    result.ran              = ran;
    result.interval_seconds = interval_nxt;
  end

  property p_digit_limit;
    @(posedge clk) disable iff (!rst_n)
      digit_count_r <= DCOUNT_W'(MAX_DIGITS);
  endproperty
  a_digit_limit: assert property (p_digit_limit)
    else $error("digit count ran past the entry limit");

  property p_service_clears_run;
    @(posedge clk) disable iff (!rst_n)
      (step && item.action == ACT_SERVICE && flag_bits_r[FLAG_RUN])
        |=> (!flag_bits_r[FLAG_RUN] && !flag_bits_r[FLAG_ZERO]);
  endproperty
  a_service_clears_run: assert property (p_service_clears_run)
    else $error("service run left run or zero bit set");

  property p_idle_holds;
    @(posedge clk) disable iff (!rst_n)
      !step |=> ($stable(flag_bits_r) && $stable(interval_r) && $stable(tick_count_r));
  endproperty
  a_idle_holds: assert property (p_idle_holds)
    else $error("state changed without an item");

  property p_strobes_need_run;
    @(posedge clk) disable iff (!rst_n)
      !ran |-> (!sample_now && !zero_now);
  endproperty
  a_strobes_need_run: assert property (p_strobes_need_run)
    else $error("sample or zero request without a run");

endmodule

FILE: src/command_flag_sequencer.sv
// Command flag sequencer: one result per item, passing through the input
// register, then the result register; a receiver stall can hold it between them.
// Throughput is one item per cycle while out_stall is low; the core updates its
// state once per item. Reset (rst_n low, synchronous) clears flags, tick and
// digit state and output levels, sets the interval to one, and empties both
// stages. Depends on cfs_pkg, cfs_in_reg and cfs_core.
module command_flag_sequencer #(
  parameter int MAX_DIGITS = cfs_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfs_pkg::out_item_t out_data
);
  import cfs_pkg::*;

  logic      stage_valid;
  in_item_t  stage_data;
  logic      advance;
  out_item_t result;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Move an item forward when the result register is free or draining
  assign advance = stage_valid && (!out_valid_r || !out_stall);

  cfs_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .take        (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  cfs_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_data),
    .result (result)
  );

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load result on each step
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  property p_step_shows_result;
    @(posedge clk) disable iff (!rst_n) advance |=> out_valid_r;
  endproperty
  a_step_shows_result: assert property (p_step_shows_result)
    else $error("stepped item produced no result");

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n) (out_valid_r && out_stall) |-> !advance;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("stalled result overwritten");

  property p_stall_means_full;
    @(posedge clk) disable iff (!rst_n) in_stall |-> (stage_valid && out_valid_r);
  endproperty
  a_stall_means_full: assert property (p_stall_means_full)
    else $error("input stalled while the pipeline had room");

endmodule

FILE: tb/sv/command_flag_sequencer_tb.sv
// Self-checking testbench for command_flag_sequencer: a directed table, then random
// command, tick, service and mask sequences under random sender gaps and receiver stalls.
// Depends on cfs_pkg and the command_flag_sequencer RTL.
module command_flag_sequencer_tb;
  import cfs_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 800;
  localparam int DIRECTED_ROWS  = 25;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PRINT_LIMIT    = 40;
  localparam int DIGIT_LIMIT    = MAX_DIGITS_DEF;

  // Action codes the block does not define, and ASCII '0'
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_t;

  // One row of the directed table; want is used only where checked is set
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [7:0] flag_mask;
    logic       checked;
    out_item_t  want;
  } dir_row_t;

  typedef struct packed {
    in_item_t  item;
    logic      checked;
    out_item_t want;
    logic      drain;
  } stim_item_t;

  // Directed table: fields {flags, sample, zero, rs232, 12V, ran, interval}
  localparam dir_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{ACT_SERVICE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{ACT_TICK,    8'h00, 8'h00, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{ACT_COMMAND, CH_A,  8'h00, 1'b1, '{8'h81, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{ACT_COMMAND, CH_C,  8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_D,  8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_E,  8'h00, 1'b0, '0},
    '{ACT_SERVICE, 8'hFF, 8'hFF, 1'b1, '{8'h19, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd1}},
    '{ACT_COMMAND, CH_B,  8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_ZERO + 8'd1, 8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_ZERO + 8'd2, 8'h00, 1'b0, '0},
    // non-digit byte still enters the value
    '{ACT_COMMAND, 8'h7A, 8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_A,  8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_ZERO + 8'd9, 8'h00, 1'b0, '0},
    // fifth digit is dropped
    '{ACT_COMMAND, CH_ZERO + 8'd7, 8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_B,  8'h00, 1'b0, '0},
    '{ACT_SET,     8'h00, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1949}},
    '{ACT_COMMAND, 8'hFF, 8'h00, 1'b0, '0},
    '{ACT_COMMAND, 8'h00, 8'h00, 1'b0, '0},
    '{ACT_CLEAR,   8'h00, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1949}},
    '{ACT_COMMAND, CH_F,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1}},
    // empty entry gives a zero interval
    '{ACT_COMMAND, CH_B,  8'h00, 1'b0, '0},
    '{ACT_COMMAND, CH_B,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0}},
    '{ACT_TICK,    8'h00, 8'h00, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0}},
    '{ACT_SPARE_HI, 8'hFF, 8'hFF, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0}},
    '{ACT_SERVICE, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predicted block state
  logic [7:0]          seq_flags;
  logic [15:0]         seq_interval;
  logic [15:0]         seq_ticks;
  logic [DCOUNT_W-1:0] seq_digit_count;
  logic [15:0]         seq_digit_value;
  logic                seq_rs232;
  logic                seq_power;

  stim_item_t  stim_q[$];
  out_item_t   pending_status[$];
  logic        drain_next;
  int          mismatch_count;
  int          results_checked;
  int          runs_seen;
  int          sent_count;
  stall_mode_t stall_mode;
  int          stall_left;
  int          stall_tick;

  command_flag_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_checked, name, got, want));
    end
  endtask

  // Advance the predicted state by one item and return the status it yields
  function automatic out_item_t compute_status(in_item_t item);
    out_item_t  res;
    logic [7:0] c;
    res = '0;
    c = item.data_byte;
    case (item.action)
      ACT_COMMAND: begin
        if (c == CH_A) begin
          seq_flags[FLAG_SAMPLE] = ~seq_flags[FLAG_SAMPLE];
        end else if (c == CH_B) begin
          if (seq_flags[FLAG_ENTRY]) begin
            seq_flags[FLAG_ENTRY] = 1'b0;
            seq_interval = seq_digit_value;
          end else begin
            seq_flags[FLAG_ENTRY] = 1'b1;
          end
          seq_digit_count = '0;
          seq_digit_value = '0;
        end else if (seq_flags[FLAG_ENTRY]) begin
          // any byte but a or b is a digit while entry is open, wrapping at 16 bits
          if (seq_digit_count < DIGIT_LIMIT) begin
            seq_digit_value = seq_digit_value * 16'd10 + {8'h00, c} - DIGIT_BASE;
            seq_digit_count = seq_digit_count + 1'b1;
          end
        end else if (c == CH_C) begin
          seq_flags[FLAG_ZERO] = ~seq_flags[FLAG_ZERO];
        end else if (c == CH_D) begin
          seq_flags[FLAG_RS232] = ~seq_flags[FLAG_RS232];
        end else if (c == CH_E) begin
          seq_flags[FLAG_V12] = ~seq_flags[FLAG_V12];
        end else if (c == CH_F) begin
          seq_flags = '0;
          seq_interval = 16'd1;
          seq_ticks = '0;
        end
      end
      ACT_TICK: begin
        seq_ticks = seq_ticks + 16'd1;
        if (seq_ticks >= seq_interval) begin
          seq_flags[FLAG_RUN] = 1'b1;
          seq_ticks = '0;
        end
      end
      ACT_SERVICE: begin
        if (seq_flags[FLAG_RUN]) begin
          res.ran = 1'b1;
          res.sample_now = seq_flags[FLAG_SAMPLE];
          res.depth_zero_now = seq_flags[FLAG_ZERO];
          seq_rs232 = seq_flags[FLAG_RS232];
          seq_power = seq_flags[FLAG_V12];
          seq_flags[FLAG_RUN] = 1'b0;
          seq_flags[FLAG_ZERO] = 1'b0;
        end
      end
      ACT_SET:   seq_flags = seq_flags | item.flag_mask;
      ACT_CLEAR: seq_flags = seq_flags & ~item.flag_mask;
      default: ;
    endcase
    res.flags = seq_flags;
    res.rs232_on = seq_rs232;
    res.power12_on = seq_power;
    res.interval_seconds = seq_interval;
    return res;
  endfunction

  task automatic push_item(logic [2:0] act, logic [7:0] data, logic [7:0] mask);
    stim_item_t s;
    s = '0;
    s.item.action = act;
    s.item.data_byte = data;
    s.item.flag_mask = mask;
    s.drain = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(s);
  endtask

  // Random part: mostly well-formed entries, tick runs and services, some noise
  task automatic build_random();
    int         start;
    int         pick;
    int         count;
    logic [7:0] digit_byte;
    start = stim_q.size();
    drain_next = 1'b1;
    while (stim_q.size() - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
        push_item(ACT_COMMAND, CH_B, 8'($urandom));
        repeat (count) begin
          case ($urandom_range(0, 19))
            0:       digit_byte = CH_A;
            1, 2:    digit_byte = 8'($urandom);
            default: digit_byte = CH_ZERO + 8'($urandom_range(0, 9));
          endcase
          push_item(ACT_COMMAND, digit_byte, 8'($urandom));
        end
        // leave some entries open
        if ($urandom_range(0, 9) != 0) begin
          push_item(ACT_COMMAND, CH_B, 8'($urandom));
        end
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 12)) push_item(ACT_TICK, 8'($urandom), 8'($urandom));
      end else if (pick < 64) begin
        repeat ($urandom_range(1, 2)) push_item(ACT_SERVICE, 8'($urandom), 8'($urandom));
      end else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0:       digit_byte = CH_A;
          1:       digit_byte = CH_C;
          2:       digit_byte = CH_D;
          default: digit_byte = CH_E;
        endcase
        push_item(ACT_COMMAND, digit_byte, 8'($urandom));
      end else if (pick < 87) begin
        digit_byte = $urandom_range(0, 1) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
        push_item($urandom_range(0, 1) ? ACT_SET : ACT_CLEAR, 8'($urandom), digit_byte);
      end else if (pick < 91) begin
        push_item(ACT_COMMAND, CH_F, 8'($urandom));
      end else if (pick < 97) begin
        push_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
      end else if (pick < 98) begin
        push_item($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI,
                  8'($urandom), 8'($urandom));
      end else begin
        drain_next = 1'b1;
      end
    end
  endtask

  // Receiver: stall on a pattern whose mode is redrawn when its random run length ends
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode = STALL_NONE;
      stall_left = 0;
      stall_tick = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(40, 240);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= (stall_tick % 5) < 2;
        default:        out_stall <= (stall_tick % 24) < 14;
      endcase
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result, flags 0x%0h", out_data.flags));
      end else begin
        want = pending_status.pop_front();
        compare_field("flags", out_data.flags, want.flags);
        compare_field("sample_now", out_data.sample_now, want.sample_now);
        compare_field("depth_zero_now", out_data.depth_zero_now, want.depth_zero_now);
        compare_field("rs232_on", out_data.rs232_on, want.rs232_on);
        compare_field("power12_on", out_data.power12_on, want.power12_on);
        compare_field("ran", out_data.ran, want.ran);
        compare_field("interval_seconds", out_data.interval_seconds,
                      want.interval_seconds);
        if (out_data.ran) begin
          runs_seen++;
        end
        results_checked++;
      end
    end
  end

  // Sender: reset, then walk the stimulus in bursts with random gaps
  initial begin
    stim_item_t row;
    out_item_t  status;
    int         burst_left;
    int         gap;
    seq_flags = '0;
    seq_interval = 16'd1;
    seq_ticks = '0;
    seq_digit_count = '0;
    seq_digit_value = '0;
    seq_rs232 = 1'b0;
    seq_power = 1'b0;
    mismatch_count = 0;
    results_checked = 0;
    runs_seen = 0;
    sent_count = 0;
    drain_next = 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      push_item(DIRECTED_TABLE[i].action, DIRECTED_TABLE[i].data_byte,
                DIRECTED_TABLE[i].flag_mask);
      stim_q[i].checked = DIRECTED_TABLE[i].checked;
      stim_q[i].want = DIRECTED_TABLE[i].want;
    end
    build_random();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    foreach (stim_q[i]) begin
      row = stim_q[i];
      // hold off until every expected result has come
      if (row.drain && pending_status.size() != 0) begin
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 48);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid <= 1'b1;
      in_data <= row.item;
      do @(posedge clk); while (in_stall);
      status = compute_status(row.item);
      pending_status.push_back(row.checked ? row.want : status);
      sent_count++;
    end
    in_valid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transfers (%0d from the directed table), checked %0d results.",
             sent_count, DIRECTED_ROWS, results_checked);
    $display("Service runs fired: %0d, mismatches: %0d.", runs_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Timeout with %0d results outstanding", pending_status.size());
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
src/cfs_pkg.sv
src/cfs_in_reg.sv
src/cfs_core.sv
src/command_flag_sequencer.sv
tb/sv/command_flag_sequencer_tb.sv
